### rtl/r2fft_pkg.sv
// Shared types, constants and codes for the radix-2 complex FFT block.
`timescale 1ns / 1ps
package r2fft_pkg;

  // Fixed field widths
  localparam int DATA_W     = 36;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int ADDR_MAX_W = 16;

  // Parameter defaults
  localparam int MAX_LEN_DEF       = 4096;
  localparam int TWIDDLE_WIDTH_DEF = 16;

  // Register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_LOG2_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE  = 1'b1;
  localparam logic [3:0]           LOG2_LEN_RST = 4'd10;

  // Request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] sample_re;
    logic signed [DATA_W-1:0] sample_im;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_re;
    logic signed [DATA_W-1:0] out_im;
    logic                     out_last;
  } out_res_t;

  // Store write data select
  typedef enum logic [1:0] {
    WSEL_SAMPLE,
    WSEL_DIFF,
    WSEL_SUM
  } wsel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic                  st_we;
    wsel_t                 wsel;
    logic [ADDR_MAX_W-1:0] st_waddr;
    logic [ADDR_MAX_W-1:0] st_raddr;
    logic [ADDR_MAX_W-1:0] tw_raddr;
    logic                  cap_x;
    logic                  cap_w;
    logic                  cap_a;
    logic                  mul_en;
    logic                  add_en;
    logic                  sum_en;
    logic                  out_load;
    logic                  out_last;
    logic                  inverse;
    logic [3:0]            lg;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

  typedef enum logic [3:0] {
    C_INIT,
    C_IDLE,
    C_BF_RDJ,
    C_BF_RDI,
    C_BF_CAPA,
    C_BF_ADD,
    C_BF_WRJ,
    C_BF_WRI,
    C_RDW
  } ctrl_state_t;

  typedef enum logic [3:0] {
    T_X,
    T_XR,
    T_X2,
    T_X2R,
    T_TM,
    T_DIVLD,
    T_DIV,
    T_TUP,
    T_SM,
    T_SR,
    T_WR,
    T_DONE
  } tw_state_t;

endpackage

### rtl/r2fft_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module r2fft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/r2fft_twgen.sv
// Twiddle table builder: fixed-point Taylor sin/cos on one shared multiplier.
`timescale 1ns / 1ps
module r2fft_twgen #(
  parameter int MAX_LEN       = 4096,
  parameter int TWIDDLE_WIDTH = 16,
  localparam int MAXLG = $clog2(MAX_LEN + 1) - 1,
  localparam int TAW   = (MAXLG > 1) ? MAXLG - 1 : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       tw_we,
  output logic [TAW-1:0]             tw_waddr,
  output logic [2*TWIDDLE_WIDTH-1:0] tw_wdata,
  output logic                       done
);
  import r2fft_pkg::*;

  localparam int F   = TWIDDLE_WIDTH - 1;
  localparam int QSH = 30 - F;
  localparam logic [TAW-1:0] IDX_LAST = TAW'((1 << (MAXLG - 1)) - 1);
  localparam logic [32:0]    TWO_PI_Q30 = 33'd6746518852;
  localparam logic [30:0]    Q30_ONE    = 31'h4000_0000;

  // Taylor divisors, highest term first, as ceil(2^k/d) with k = 30 + ceil(log2 d);
  // exact floor division for any 30-bit dividend
  function automatic logic [32:0] recip_mul(input logic cos_ph, input logic [2:0] k);
    logic [32:0] m;
    m = 33'd1073741824;
    if (!cos_ph) begin
      case (k)
        3'd0:    m = 33'd1249445032;  // 110
        3'd1:    m = 33'd1908874354;  // 72
        3'd2:    m = 33'd1636178018;  // 42
        3'd3:    m = 33'd1717986919;  // 20
        default: m = 33'd1431655766;  // 6
      endcase
    end else begin
      case (k)
        3'd0:    m = 33'd2082408386;  // 132
        3'd1:    m = 33'd1527099484;  // 90
        3'd2:    m = 33'd1227133514;  // 56
        3'd3:    m = 33'd1145324613;  // 30
        3'd4:    m = 33'd1431655766;  // 12
        default: m = 33'd1073741824;  // 2
      endcase
    end
    return m;
  endfunction

  function automatic logic [5:0] recip_shift(input logic cos_ph, input logic [2:0] k);
    logic [5:0] s;
    s = 6'd31;
    if (!cos_ph) begin
      case (k)
        3'd0:    s = 6'd37;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        default: s = 6'd33;
      endcase
    end else begin
      case (k)
        3'd0:    s = 6'd38;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        3'd4:    s = 6'd34;
        default: s = 6'd31;
      endcase
    end
    return s;
  endfunction

  // Round half up to F fraction bits, saturate just below one
  function automatic logic [F-1:0] quant(input logic [30:0] v);
    logic [31:0] q;
    q = ({1'b0, v} + (32'd1 << (QSH - 1))) >> QSH;
    if (q > 32'((1 << F) - 1)) begin
      q = 32'((1 << F) - 1);
    end
    return q[F-1:0];
  endfunction

  tw_state_t      state_r, state_nxt;
  logic [TAW-1:0] idx_r, idx_nxt;
  logic [2:0]     n_r, n_nxt;
  logic           cos_r, cos_nxt;

  logic [63:0] prod_r;
  logic [29:0] x_r, x_nxt;
  logic [29:0] x2_r, x2_nxt;
  logic [30:0] t_r, t_nxt;
  logic [30:0] s_r, s_nxt;
  logic [29:0] dv_r, dv_nxt;

  logic [31:0] ph;
  logic [1:0]  oct;
  logic [29:0] rr;
  logic [30:0] ma;
  logic [32:0] mb;
  logic [63:0] rnd;
  logic [32:0] rmul;
  logic [5:0]  rsh;
  logic [63:0] quo;
  logic [F-1:0] cq, sq;
  logic signed [TWIDDLE_WIDTH-1:0] wr, wi;

  // Phase of the current entry, folded into the first octant
  assign ph  = 32'(idx_r) << (32 - MAXLG);
  assign oct = ph[30:29];
  assign rr  = oct[0] ? (30'h2000_0000 - {1'b0, ph[28:0]}) : {1'b0, ph[28:0]};

  assign rmul = recip_mul(cos_r, n_r);
  assign rsh  = recip_shift(cos_r, n_r);
  assign quo  = prod_r >> rsh;

  // Multiplier operand select
  always_comb begin
    ma = 31'(x2_r);
    mb = 33'(t_r);
    case (state_r)
      T_X: begin
        ma = 31'(rr);
        mb = TWO_PI_Q30;
      end
      T_X2: begin
        ma = 31'(x_r);
        mb = 33'(x_r);
      end
      T_DIV: begin
        ma = 31'(dv_r);
        mb = rmul;
      end
      T_SM: begin
        ma = 31'(x_r);
        mb = 33'(t_r);
      end
      default: begin
        ma = 31'(x2_r);
        mb = 33'(t_r);
      end
    endcase
  end

  // Octant mapping of the quantized pair
  always_comb begin
    cq = quant(t_r);
    sq = quant(s_r);
    case (oct)
      2'd0: begin
        wr = $signed({1'b0, cq});
        wi = $signed({1'b0, sq});
      end
      2'd1: begin
        wr = $signed({1'b0, sq});
        wi = $signed({1'b0, cq});
      end
      2'd2: begin
        wr = -$signed({1'b0, sq});
        wi = $signed({1'b0, cq});
      end
      default: begin
        wr = -$signed({1'b0, cq});
        wi = $signed({1'b0, sq});
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    cos_nxt   = cos_r;
    x_nxt     = x_r;
    x2_nxt    = x2_r;
    t_nxt     = t_r;
    s_nxt     = s_r;
    dv_nxt    = dv_r;
    rnd       = 64'd0;
    tw_we     = 1'b0;
    case (state_r)
      T_X:  state_nxt = T_XR;
      T_XR: begin
        rnd       = prod_r + 64'h8000_0000;
        x_nxt     = rnd[61:32];
        state_nxt = T_X2;
      end
      T_X2: state_nxt = T_X2R;
      T_X2R: begin
        rnd       = prod_r + 64'h2000_0000;
        x2_nxt    = rnd[59:30];
        t_nxt     = Q30_ONE;
        n_nxt     = 3'd0;
        cos_nxt   = 1'b0;
        state_nxt = T_TM;
      end
      T_TM: state_nxt = T_DIVLD;
      T_DIVLD: begin
        dv_nxt    = prod_r[59:30];
        state_nxt = T_DIV;
      end
      // Divide by the term's constant through its reciprocal
      T_DIV: state_nxt = T_TUP;
      T_TUP: begin
        t_nxt = Q30_ONE - {1'b0, quo[29:0]};
        n_nxt = n_r + 3'd1;
        if (!cos_r && n_r == 3'd4) begin
          state_nxt = T_SM;
        end else if (cos_r && n_r == 3'd5) begin
          state_nxt = T_WR;
        end else begin
          state_nxt = T_TM;
        end
      end
      T_SM: state_nxt = T_SR;
      T_SR: begin
        s_nxt     = prod_r[60:30];
        t_nxt     = Q30_ONE;
        n_nxt     = 3'd0;
        cos_nxt   = 1'b1;
        state_nxt = T_TM;
      end
      T_WR: begin
        tw_we = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = T_DONE;
        end else begin
          idx_nxt   = idx_r + TAW'(1);
          state_nxt = T_X;
        end
      end
      T_DONE: state_nxt = T_DONE;
      default: state_nxt = T_X;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_X;
      idx_r   <= '0;
      n_r     <= 3'd0;
      cos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      n_r     <= n_nxt;
      cos_r   <= cos_nxt;
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(ma) * 64'(mb);
    x_r    <= x_nxt;
    x2_r   <= x2_nxt;
    t_r    <= t_nxt;
    s_r    <= s_nxt;
    dv_r   <= dv_nxt;
  end

  assign tw_waddr = idx_r;
  assign tw_wdata = {wr, wi};
  assign done     = (state_r == T_DONE);

endmodule

### rtl/r2fft_ctrl.sv
// Controller: frame counters, butterfly address generation and request handling.
`timescale 1ns / 1ps
module r2fft_ctrl #(
  parameter int MAX_LEN = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic                               cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [r2fft_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               tw_done,
  input  r2fft_pkg::dp_sts_t                 sts,
  output r2fft_pkg::dp_cmd_t                 cmd
);
  import r2fft_pkg::*;

  localparam int MAXLG = $clog2(MAX_LEN + 1) - 1;

  ctrl_state_t      state_r, state_nxt;
  logic [MAXLG-1:0] load_count_r, load_count_nxt;
  logic [MAXLG-1:0] read_count_r, read_count_nxt;
  logic             frame_ready_r, frame_ready_nxt;
  logic [3:0]       s_r, s_nxt;
  logic [MAXLG-1:0] b_r, b_nxt;
  logic [3:0]       log2_len_r, log2_len_nxt;
  logic             inverse_r, inverse_nxt;

  logic [3:0]       lg;
  logic [MAXLG:0]   n;
  logic [MAXLG-1:0] n_m1, half_m1;
  logic [MAXLG-1:0] load_idx, rev_full, load_addr;
  logic [MAXLG:0]   load_next;
  logic [MAXLG-1:0] span, m, ia, ja, tidx;
  logic [4:0]       tsh;

  // Clamp the length to at least two points and to what the store holds
  always_comb begin
    lg = log2_len_r;
    if (lg == 4'd0) begin
      lg = 4'd1;
    end
    if (32'(lg) > MAXLG) begin
      lg = 4'(MAXLG);
    end
  end

  assign n       = (MAXLG + 1)'(1) << lg;
  assign n_m1    = MAXLG'(n - (MAXLG + 1)'(1));
  assign half_m1 = MAXLG'((n >> 1) - (MAXLG + 1)'(1));

  // Loads land at bit-reversed addresses, so no permutation pass is needed
  assign load_idx  = frame_ready_r ? '0 : load_count_r;
  assign load_next = {1'b0, load_idx} + (MAXLG + 1)'(1);
  always_comb begin
    for (int k = 0; k < MAXLG; k++) begin
      rev_full[k] = load_idx[MAXLG-1-k];
    end
  end
  assign load_addr = rev_full >> (5'(MAXLG) - {1'b0, lg});

  // Butterfly pair and twiddle index for stage s, butterfly b
  assign span = MAXLG'(1) << s_r;
  assign m    = b_r & (span - MAXLG'(1));
  assign ia   = ((b_r >> s_r) << (s_r + 4'd1)) | m;
  assign ja   = ia | span;
  assign tsh  = 5'(MAXLG - 1) - {1'b0, s_r};
  assign tidx = m << tsh;

  always_comb begin
    state_nxt       = state_r;
    load_count_nxt  = load_count_r;
    read_count_nxt  = read_count_r;
    frame_ready_nxt = frame_ready_r;
    s_nxt           = s_r;
    b_nxt           = b_r;
    log2_len_nxt    = log2_len_r;
    inverse_nxt     = inverse_r;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.wsel        = WSEL_SAMPLE;
    cmd.st_raddr    = ADDR_MAX_W'(read_count_r);
    cmd.inverse     = inverse_r;
    cmd.lg          = lg;
    case (state_r)
      // Wait for the twiddle table
      C_INIT: begin
        if (tw_done) begin
          state_nxt = C_IDLE;
        end
      end
      C_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            cmd.st_we       = 1'b1;
            cmd.st_waddr    = ADDR_MAX_W'(load_addr);
            frame_ready_nxt = 1'b0;
            read_count_nxt  = '0;
            if (load_next == n) begin
              load_count_nxt = '0;
              s_nxt          = 4'd0;
              b_nxt          = '0;
              state_nxt      = C_BF_RDJ;
            end else begin
              load_count_nxt = load_next[MAXLG-1:0];
            end
          end else if (frame_ready_r) begin
            state_nxt = C_RDW;
          end
        end
      end
      // Butterfly: read both points and the twiddle, multiply, add, write back
      C_BF_RDJ: begin
        cmd.st_raddr = ADDR_MAX_W'(ja);
        cmd.tw_raddr = ADDR_MAX_W'(tidx);
        state_nxt    = C_BF_RDI;
      end
      C_BF_RDI: begin
        cmd.st_raddr = ADDR_MAX_W'(ia);
        cmd.cap_x    = 1'b1;
        cmd.cap_w    = 1'b1;
        state_nxt    = C_BF_CAPA;
      end
      C_BF_CAPA: begin
        cmd.cap_a  = 1'b1;
        cmd.mul_en = 1'b1;
        state_nxt  = C_BF_ADD;
      end
      C_BF_ADD: begin
        cmd.add_en = 1'b1;
        state_nxt  = C_BF_WRJ;
      end
      C_BF_WRJ: begin
        cmd.st_we    = 1'b1;
        cmd.wsel     = WSEL_DIFF;
        cmd.st_waddr = ADDR_MAX_W'(ja);
        cmd.sum_en   = 1'b1;
        state_nxt    = C_BF_WRI;
      end
      C_BF_WRI: begin
        cmd.st_we    = 1'b1;
        cmd.wsel     = WSEL_SUM;
        cmd.st_waddr = ADDR_MAX_W'(ia);
        state_nxt    = C_BF_RDJ;
        if (b_r == half_m1) begin
          b_nxt = '0;
          if (s_r == lg - 4'd1) begin
            frame_ready_nxt = 1'b1;
            state_nxt       = C_IDLE;
          end else begin
            s_nxt = s_r + 4'd1;
          end
        end else begin
          b_nxt = b_r + MAXLG'(1);
        end
      end
      // Read data is out of the store; hand it over once the output is free
      C_RDW: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (read_count_r == n_m1);
          if (read_count_r == n_m1) begin
            frame_ready_nxt = 1'b0;
            read_count_nxt  = '0;
          end else begin
            read_count_nxt = read_count_r + MAXLG'(1);
          end
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase

    // Register writes abandon any frame in progress
    if (cfg_we) begin
      if (cfg_index == REG_LOG2_LEN) begin
        log2_len_nxt = cfg_data;
      end else begin
        inverse_nxt = cfg_data[0];
      end
      load_count_nxt  = '0;
      read_count_nxt  = '0;
      frame_ready_nxt = 1'b0;
      if (state_r != C_INIT && state_r != C_RDW) begin
        state_nxt = C_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= C_INIT;
      load_count_r  <= '0;
      read_count_r  <= '0;
      frame_ready_r <= 1'b0;
      s_r           <= 4'd0;
      b_r           <= '0;
      log2_len_r    <= LOG2_LEN_RST;
      inverse_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      load_count_r  <= load_count_nxt;
      read_count_r  <= read_count_nxt;
      frame_ready_r <= frame_ready_nxt;
      s_r           <= s_nxt;
      b_r           <= b_nxt;
      log2_len_r    <= log2_len_nxt;
      inverse_r     <= inverse_nxt;
    end
  end

endmodule

### rtl/r2fft_dp.sv
// Datapath: sample store, twiddle table, complex butterfly and output register.
`timescale 1ns / 1ps
module r2fft_dp #(
  parameter int MAX_LEN       = 4096,
  parameter int TWIDDLE_WIDTH = 16,
  localparam int MAXLG = $clog2(MAX_LEN + 1) - 1,
  localparam int TAW   = (MAXLG > 1) ? MAXLG - 1 : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  r2fft_pkg::dp_cmd_t                    cmd,
  output r2fft_pkg::dp_sts_t                    sts,
  input  logic signed [r2fft_pkg::DATA_W-1:0]   sample_re,
  input  logic signed [r2fft_pkg::DATA_W-1:0]   sample_im,
  input  logic                                  tw_we,
  input  logic [TAW-1:0]                        tw_waddr,
  input  logic [2*TWIDDLE_WIDTH-1:0]            tw_wdata,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output r2fft_pkg::out_res_t                   out_res
);
  import r2fft_pkg::*;

  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TD  = 1 << (MAXLG - 1);
  localparam int TW  = TWIDDLE_WIDTH;
  localparam int F   = TW - 1;
  localparam int PW  = DATA_W + TW;
  localparam int TTW = DATA_W + 2;
  localparam int SW  = DATA_W + 3;
  localparam logic signed [PW:0] HALF = (PW + 1)'(1) <<< (F - 1);

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'({1'b0, {(DATA_W - 1){1'b1}}});
    lo = ~hi;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  logic [2*DATA_W-1:0] st_wdata, st_rdata;
  logic [2*TW-1:0]     tw_rdata;

  logic signed [DATA_W-1:0] x_re_r, x_im_r, a_re_r, a_im_r;
  logic signed [TW-1:0]     wr_r, wi_r;
  logic signed [PW-1:0]     p1_r, p2_r, p3_r, p4_r;
  logic signed [TTW-1:0]    t_re_r, t_im_r;
  logic signed [DATA_W-1:0] sum_re_r, sum_im_r;
  out_res_t                 out_r;
  logic                     out_valid_r;

  logic signed [TW-1:0]     wi_raw, wi_eff;
  logic signed [PW:0]       sr, si;
  logic signed [DATA_W-1:0] dif_re, dif_im, sum_re, sum_im;
  logic signed [DATA_W-1:0] rd_re, rd_im;
  logic signed [DATA_W:0]   half_o, sc_re, sc_im;

  // Complex sample store
  r2fft_ram #(
    .WIDTH(2 * DATA_W),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (cmd.st_we),
    .waddr(cmd.st_waddr[AW-1:0]),
    .wdata(st_wdata),
    .raddr(cmd.st_raddr[AW-1:0]),
    .rdata(st_rdata)
  );

  // Twiddle table, one entry per phase step of the longest transform over the first half turn
  r2fft_ram #(
    .WIDTH(2 * TW),
    .DEPTH(TD)
  ) u_twtab (
    .clk  (clk),
    .we   (tw_we),
    .waddr(tw_waddr),
    .wdata(tw_wdata),
    .raddr(cmd.tw_raddr[TAW-1:0]),
    .rdata(tw_rdata)
  );

  // Store write data select
  always_comb begin
    case (cmd.wsel)
      WSEL_SAMPLE: st_wdata = {sample_re, sample_im};
      WSEL_DIFF:   st_wdata = {dif_re, dif_im};
      WSEL_SUM:    st_wdata = {sum_re_r, sum_im_r};
      default:     st_wdata = {sample_re, sample_im};
    endcase
  end

  // Forward conjugates the twiddle
  assign wi_raw = tw_rdata[TW-1:0];
  assign wi_eff = cmd.inverse ? wi_raw : -wi_raw;

  // Rounded twiddle products
  assign sr = {p1_r[PW-1], p1_r} - {p2_r[PW-1], p2_r} + HALF;
  assign si = {p3_r[PW-1], p3_r} + {p4_r[PW-1], p4_r} + HALF;

  // Saturated butterfly outputs
  assign dif_re = sat(SW'(a_re_r) - SW'(t_re_r));
  assign dif_im = sat(SW'(a_im_r) - SW'(t_im_r));
  assign sum_re = sat(SW'(a_re_r) + SW'(t_re_r));
  assign sum_im = sat(SW'(a_im_r) + SW'(t_im_r));

  // Inverse divide by N with rounding on the way out
  assign rd_re  = st_rdata[2*DATA_W-1:DATA_W];
  assign rd_im  = st_rdata[DATA_W-1:0];
  assign half_o = (DATA_W + 1)'(1) <<< (cmd.lg - 4'd1);
  assign sc_re  = ((DATA_W + 1)'(rd_re) + half_o) >>> cmd.lg;
  assign sc_im  = ((DATA_W + 1)'(rd_im) + half_o) >>> cmd.lg;

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      x_re_r <= rd_re;
      x_im_r <= rd_im;
    end
    if (cmd.cap_w) begin
      wr_r <= tw_rdata[2*TW-1:TW];
      wi_r <= wi_eff;
    end
    if (cmd.cap_a) begin
      a_re_r <= rd_re;
      a_im_r <= rd_im;
    end
    if (cmd.mul_en) begin
      p1_r <= PW'(x_re_r) * PW'(wr_r);
      p2_r <= PW'(x_im_r) * PW'(wi_r);
      p3_r <= PW'(x_im_r) * PW'(wr_r);
      p4_r <= PW'(x_re_r) * PW'(wi_r);
    end
    if (cmd.add_en) begin
      t_re_r <= sr[PW:F];
      t_im_r <= si[PW:F];
    end
    if (cmd.sum_en) begin
      sum_re_r <= sum_re;
      sum_im_r <= sum_im;
    end
    if (cmd.out_load) begin
      out_r.out_re   <= cmd.inverse ? sc_re[DATA_W-1:0] : rd_re;
      out_r.out_im   <= cmd.inverse ? sc_im[DATA_W-1:0] : rd_im;
      out_r.out_last <= cmd.out_last;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_res      = out_r;

endmodule

### rtl/radix2_complex_fft.sv
// Top level of the radix-2 decimation-in-time complex FFT block.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | in_req  (cmd, sample_re, sample_im)
//  out_    | output    | out_valid / out_ready| out_res (out_re, out_im, out_last)
//  cfg_    | input     | cfg_we               | cfg_index, cfg_data
//
//  A load request is written straight into the store; a read request goes through the store's
//  registered read port to the output register. The N-th load starts the transform: each
//  butterfly reads both points and its twiddle, multiplies, adds and writes both results back,
//  one butterfly after the other, and in_ready stays low until the last one is written.
//  After reset the twiddle table is built, one entry at a time for MAX_LEN/2 entries, with
//  in_ready low; register writes are taken. A result waiting in the output register holds
//  the next accepted read request, with in_ready low, until that result is taken.
`timescale 1ns / 1ps
module radix2_complex_fft #(
  parameter int MAX_LEN       = r2fft_pkg::MAX_LEN_DEF,
  parameter int TWIDDLE_WIDTH = r2fft_pkg::TWIDDLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  r2fft_pkg::in_req_t              in_req,
  output logic                            out_valid,
  input  logic                            out_ready,
  output r2fft_pkg::out_res_t             out_res,
  input  logic                            cfg_we,
  input  logic [r2fft_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2fft_pkg::CFG_W-1:0]     cfg_data
);
  import r2fft_pkg::*;

  localparam int MAXLG = $clog2(MAX_LEN + 1) - 1;
  localparam int TAW   = (MAXLG > 1) ? MAXLG - 1 : 1;

  dp_cmd_t                    cmd;
  dp_sts_t                    sts;
  logic                       tw_we;
  logic [TAW-1:0]             tw_waddr;
  logic [2*TWIDDLE_WIDTH-1:0] tw_wdata;
  logic                       tw_done;

  // Twiddle table builder
  r2fft_twgen #(
    .MAX_LEN      (MAX_LEN),
    .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
  ) u_twgen (
    .clk     (clk),
    .rst_n   (rst_n),
    .tw_we   (tw_we),
    .tw_waddr(tw_waddr),
    .tw_wdata(tw_wdata),
    .done    (tw_done)
  );

  // Controller
  r2fft_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_req.cmd),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tw_done  (tw_done),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath
  r2fft_dp #(
    .MAX_LEN      (MAX_LEN),
    .TWIDDLE_WIDTH(TWIDDLE_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .sample_re(in_req.sample_re),
    .sample_im(in_req.sample_im),
    .tw_we    (tw_we),
    .tw_waddr (tw_waddr),
    .tw_wdata (tw_wdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

endmodule
